FILE: hw/rtl/nsel_pkg.sv
// Shared types, constants and the prime table of the start nonce selector.
package nsel_pkg;

  localparam int unsigned DIV_W     = 10;  // divisor width of the shared divider
  localparam int unsigned DIV_RADIX = 4;   // quotient bits resolved per divider cycle
  localparam int unsigned DIV_STEPS = 64 / DIV_RADIX;

  localparam logic [10:0] GOLD_NUM       = 11'd1618;
  localparam logic [9:0]  GOLD_DEN       = 10'd1000;
  localparam logic [31:0] DIFF_THRESHOLD = 32'd6;

  localparam logic [1:0] STRAT_SEQ   = 2'd0;
  localparam logic [1:0] STRAT_PRIME = 2'd1;
  localparam logic [1:0] STRAT_GOLD  = 2'd2;
  localparam logic [1:0] STRAT_ADAPT = 2'd3;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_REPORT  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // The first 25 primes, addressed from zero.
  function automatic logic [6:0] prime_at(input logic [4:0] idx);
    logic [6:0] p;
    case (idx)
      5'd0:    p = 7'd2;
      5'd1:    p = 7'd3;
      5'd2:    p = 7'd5;
      5'd3:    p = 7'd7;
      5'd4:    p = 7'd11;
      5'd5:    p = 7'd13;
      5'd6:    p = 7'd17;
      5'd7:    p = 7'd19;
      5'd8:    p = 7'd23;
      5'd9:    p = 7'd29;
      5'd10:   p = 7'd31;
      5'd11:   p = 7'd37;
      5'd12:   p = 7'd41;
      5'd13:   p = 7'd43;
      5'd14:   p = 7'd47;
      5'd15:   p = 7'd53;
      5'd16:   p = 7'd59;
      5'd17:   p = 7'd61;
      5'd18:   p = 7'd67;
      5'd19:   p = 7'd71;
      5'd20:   p = 7'd73;
      5'd21:   p = 7'd79;
      5'd22:   p = 7'd83;
      5'd23:   p = 7'd89;
      default: p = 7'd97;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/nsel_div.sv
// Iterative radix-16 restoring divider: 64-bit dividend by a 10-bit divisor.
module nsel_div
  import nsel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [63:0]      quotient,
  output div_stat_t        stat
);

  localparam int unsigned CntW = $clog2(DIV_STEPS);

  logic [63:0]      quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             done;
  logic [63:0]      quo_next;
  logic [DIV_W-1:0] rem_next;

  // Four dependent compare and subtract steps per cycle. The partial
  // remainder always stays below the divisor, so one extra bit suffices.
  always_comb begin
    logic [DIV_W:0] t;
    quo_next = quo;
    rem_next = rem;
    for (int k = 0; k < DIV_RADIX; k++) begin
      t        = {rem_next, quo_next[63]};
      quo_next = {quo_next[62:0], 1'b0};
      if (t >= {1'b0, dsr}) begin
        rem_next    = DIV_W'(t - {1'b0, dsr});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = t[DIV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hw/rtl/mining_start_nonce_selector_unit.sv
// Top level of the start nonce selector: sequencer, shared multiplier and job state.
// A report word is taken and gives no result.
// A request goes straight to output in sequential mode, via two multiply states and a finish
// state under prime skew, plus the radix-16 divider under golden ratio, and via the multiply
// states and, given history, the divider when adaptive; one in flight, next taken back in idle.
// Reset is synchronous: strategy, job counter, history ring and output valid are cleared.
module mining_start_nonce_selector_unit
  import nsel_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10,
  parameter int PRIME_COUNT   = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] difficulty,
  input  logic [31:0] found_nonce,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] start_nonce
);

  localparam int unsigned PosW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SumW  = 32 + FillW;
  localparam int unsigned IdxW  = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL0 = 6'b000010,
    S_MUL1 = 6'b000100,
    S_FIN  = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [1:0]       strategy;
  logic [31:0]      job_count;
  logic [IdxW-1:0]  prime_idx;
  logic [31:0]      ring [HISTORY_DEPTH];
  logic [PosW-1:0]  ring_write_pos;
  logic [FillW-1:0] ring_fill;
  logic [SumW-1:0]  ring_sum;
  logic [31:0]      diff;
  logic [63:0]      prod;
  logic [63:0]      acc;
  logic [31:0]      res;
  logic [31:0]      res_next;

  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic [31:0]      factor;
  logic             div_start;
  logic [63:0]      div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic [63:0]      div_quo;
  div_stat_t        div_stat;
  logic             in_fire;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);
  assign factor    = (diff > DIFF_THRESHOLD) ? diff : 32'd1;

  // Operand selection for the one shared 32 by 32 multiplier.
  always_comb begin
    mul_a = job_count;
    mul_b = 32'(prime_at(5'(prime_idx)));
    case (state)
      S_MUL0: begin
        if (strategy == STRAT_GOLD) begin
          // Low half of job_count * (2^32 - 1) is the negated count.
          mul_a = 32'd0 - job_count;
          mul_b = 32'(GOLD_NUM);
        end
      end
      S_MUL1: begin
        if (strategy == STRAT_GOLD) begin
          mul_a = (job_count == 32'd0) ? 32'd0 : job_count - 32'd1;
          mul_b = 32'(GOLD_NUM);
        end else begin
          mul_a = prod[31:0];
          mul_b = factor;
        end
      end
      default: begin
        mul_a = job_count;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_start = ((state == S_MUL1) && (strategy == STRAT_ADAPT) && (ring_fill != '0))
                  || ((state == S_FIN) && (strategy == STRAT_GOLD));
  assign div_dividend = (strategy == STRAT_GOLD) ? acc + {prod[31:0], 32'd0} : 64'(ring_sum);
  assign div_divisor  = (strategy == STRAT_GOLD) ? GOLD_DEN : DIV_W'(ring_fill);

  nsel_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    res_next   = res;
    case (state)
      S_IDLE: begin
        if (in_fire && command == CMD_REQUEST) begin
          if (strategy == STRAT_SEQ) begin
            res_next   = 32'd0;
            state_next = S_OUT;
          end else begin
            state_next = S_MUL0;
          end
        end
      end
      S_MUL0: state_next = S_MUL1;
      S_MUL1: begin
        if (strategy == STRAT_ADAPT) begin
          res_next   = prod[31:0];
          state_next = (ring_fill != '0) ? S_DIV : S_OUT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (strategy == STRAT_GOLD) begin
          state_next = S_DIV;
        end else begin
          res_next   = prod[31:0];
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (strategy == STRAT_GOLD) begin
            res_next = div_quo[31:0];
          end else begin
            res_next = (div_quo[31:0] >> 8) + res;
          end
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      job_count <= '0;
      prime_idx <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        job_count <= job_count + 32'd1;
        // The residue restarts when the 32-bit counter wraps.
        if (job_count == 32'hFFFF_FFFF || prime_idx == IdxW'(PRIME_COUNT - 1)) begin
          prime_idx <= '0;
        end else begin
          prime_idx <= prime_idx + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Strategy register and history ring. A running sum is kept alongside the
  // ring; entries not yet written are zero, so replacing one is a plain swap.
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy       <= STRAT_SEQ;
      ring_write_pos <= '0;
      ring_fill      <= '0;
      ring_sum       <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      strategy <= cfg_data;
      if (cfg_data != STRAT_ADAPT) begin
        ring_write_pos <= '0;
        ring_fill      <= '0;
        ring_sum       <= '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          ring[i] <= '0;
        end
      end
    end else if (in_fire && command == CMD_REPORT && strategy == STRAT_ADAPT) begin
      ring[ring_write_pos] <= found_nonce;
      ring_sum <= ring_sum - SumW'(ring[ring_write_pos]) + SumW'(found_nonce);
      if (ring_write_pos == PosW'(HISTORY_DEPTH - 1)) begin
        ring_write_pos <= '0;
      end else begin
        ring_write_pos <= ring_write_pos + 1'b1;
      end
      if (ring_fill != FillW'(HISTORY_DEPTH)) begin
        ring_fill <= ring_fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (in_fire) begin
      diff <= difficulty;
    end
    if (state == S_MUL0 || state == S_MUL1) begin
      prod <= mul_p;
    end
    if (state == S_MUL1) begin
      acc <= prod;
    end
    if (out_load) begin
      start_nonce <= res;
    end
  end

endmodule

FILE: hw/rtl/nsel_checker.sv
// Port-level checker for the start nonce selector and its bind to the top level.
module nsel_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] start_nonce
);

  // A result word that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(start_nonce))
    else $error("result word changed or dropped while stalled");

  // A request occupies the block, so no further word is taken next cycle.
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !command |=> !in_ready)
    else $error("input taken while a request is in progress");

  // A report produces no result word.
  a_report_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command && !out_valid |=> !out_valid)
    else $error("report produced a result word");

  // A result only appears once the block has been working on a request.
  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word appeared without a request in progress");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid not cleared by reset");

endmodule

bind mining_start_nonce_selector_unit nsel_checker u_nsel_checker (.*);
